### rtl/kdc_pkg.sv
// ----------------------------------------------------------------------------
// kdc_pkg
// Shared types and constants for the k-mer counter: field widths, word
// modes, the nucleotide character codes and the character decoder.
// ----------------------------------------------------------------------------
package kdc_pkg;

   localparam int MODE_BITS   = 2;
   localparam int CHAR_BITS   = 8;
   localparam int QUERY_BITS  = 16;
   localparam int WIDX_BITS   = 16;
   localparam int CVAL_BITS   = 32;
   localparam int KLEN_BITS   = 4;
   localparam int RUN_BITS    = 4;

   localparam logic [KLEN_BITS-1:0] K_MIN   = 4'd3;
   localparam logic [KLEN_BITS-1:0] K_RESET = 4'd3;

   localparam logic [CHAR_BITS-1:0] CHAR_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_C = 8'h43;
   localparam logic [CHAR_BITS-1:0] CHAR_G = 8'h47;
   localparam logic [CHAR_BITS-1:0] CHAR_T = 8'h54;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_CHAR = 2'd0,
      MODE_EOL  = 2'd1,
      MODE_READ = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SYM_A = 2'd0,
      SYM_C = 2'd1,
      SYM_G = 2'd2,
      SYM_T = 2'd3
   } sym_code_type;

   typedef struct packed {
      logic         ok;
      sym_code_type sym;
   } sym_type;

   // Map a character to its two-bit base; ok is low for anything else.
   function automatic sym_type decode_char(input logic [CHAR_BITS-1:0] ch);
      sym_type res;
      res.ok  = 1'b1;
      res.sym = SYM_A;
      case (ch)
         CHAR_A:  res.sym = SYM_A;
         CHAR_C:  res.sym = SYM_C;
         CHAR_G:  res.sym = SYM_G;
         CHAR_T:  res.sym = SYM_T;
         default: res.ok  = 1'b0;
      endcase
      return res;
   endfunction

endpackage

### rtl/kdc_req_if.sv
// ----------------------------------------------------------------------------
// kdc_req_if
// Request channel: valid/ready handshake carrying one input word.
// ----------------------------------------------------------------------------
interface kdc_req_if;
   import kdc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MODE_BITS-1:0]  mode;
   logic [CHAR_BITS-1:0]  char_code;
   logic [QUERY_BITS-1:0] query_index;

   modport source (output valid, mode, char_code, query_index, input ready);
   modport sink   (input valid, mode, char_code, query_index, output ready);
endinterface

### rtl/kdc_rsp_if.sv
// ----------------------------------------------------------------------------
// kdc_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface kdc_rsp_if;
   import kdc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 counted;
   logic [WIDX_BITS-1:0] window_index;
   logic [CVAL_BITS-1:0] count_value;

   modport source (output valid, counted, window_index, count_value, input ready);
   modport sink   (input valid, counted, window_index, count_value, output ready);
endinterface

### rtl/kdc_ram.sv
// ----------------------------------------------------------------------------
// kdc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old contents on a same-address collision).
// ----------------------------------------------------------------------------
module kdc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dna_kmer_counter.sv
// Path: the accepting edge issues the counter RAM read and loads the stage B registers;
//   stage B writes the new count back and pushes the response word into the output queue.
// Throughput: one word per cycle while the output queue has room, set by the counter
//   RAM read-modify-write (one read port, one write port) with write-back forwarding.
// Reset: synchronous, active high; then a clearing pass writes zero to all 4**MAX_K
//   counter words (65536 at MAX_K = 8) while req_if.ready stays low.
// ----------------------------------------------------------------------------
// dna_kmer_counter
// Counts k-mers of a DNA character stream in a RAM of saturating counters
// indexed by the base-4 value of the window; a read word returns one counter.
// ----------------------------------------------------------------------------
module dna_kmer_counter #(
   parameter int MAX_K      = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [kdc_pkg::KLEN_BITS-1:0] csr_wr_data,
   kdc_req_if.sink                      req_if,
   kdc_rsp_if.source                    rsp_if
);
   import kdc_pkg::*;

   localparam int AW    = 2 * MAX_K;        // window bits = counter address bits
   localparam int DEPTH = 1 << AW;
   localparam logic [KLEN_BITS-1:0] MAX_K_C = KLEN_BITS'(MAX_K);
   localparam logic [RUN_BITS-1:0]  RUN_MAX = RUN_BITS'(MAX_K);
   localparam int FIFO_DEPTH = 3;

   // ------------------------------------------------------------------
   // Configuration: window length register
   // ------------------------------------------------------------------
   logic [KLEN_BITS-1:0] klen_ff;
   logic [KLEN_BITS-1:0] k_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= K_RESET;
      end else if (csr_wr_en) begin
         klen_ff <= csr_wr_data;
      end
   end

   // Clamp K into the supported range.
   always_comb begin
      if (klen_ff < K_MIN) begin
         k_eff = K_MIN;
      end else if (klen_ff > MAX_K_C) begin
         k_eff = MAX_K_C;
      end else begin
         k_eff = klen_ff;
      end
   end

   // ------------------------------------------------------------------
   // Clearing pass: sweep the counter RAM once after reset
   // ------------------------------------------------------------------
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (&clr_addr_ff) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage A: accept a word, update window and run, issue the RAM read
   // ------------------------------------------------------------------
   logic                 accept;
   logic [2:0]           occupancy;
   logic [1:0]           fifo_cnt_ff;
   logic                 s1_valid_ff;

   // Hold off new words unless stage B and the output queue have room.
   assign occupancy    = 3'(fifo_cnt_ff) + 3'(s1_valid_ff);
   assign req_if.ready = !clr_busy_ff && (occupancy < 3'(FIFO_DEPTH));
   assign accept       = req_if.valid && req_if.ready;

   logic [AW-1:0]       win_ff, win_in;
   logic [RUN_BITS-1:0] run_ff, run_in;
   logic [AW-1:0]       win_shift;
   logic [RUN_BITS-1:0] run_inc;
   logic [AW-1:0]       k_mask;
   logic [AW-1:0]       win_idx;
   logic [AW-1:0]       query_addr;
   logic [AW-1:0]       rd_addr;
   logic                hit_count;
   logic                hit_read;
   sym_type             sym;

   assign sym        = decode_char(req_if.char_code);
   assign win_shift  = {win_ff[AW-3:0], sym.sym};
   assign run_inc    = (run_ff < RUN_MAX) ? run_ff + RUN_BITS'(1) : run_ff;
   assign query_addr = AW'(32'(req_if.query_index));

   always_comb begin
      for (int i = 0; i < AW; i++) begin
         k_mask[i] = (i < 2 * int'(k_eff));
      end
   end

   assign win_idx = win_shift & k_mask;

   always_comb begin
      win_in    = win_ff;
      run_in    = run_ff;
      hit_count = 1'b0;
      hit_read  = 1'b0;
      rd_addr   = win_idx;
      if (accept) begin
         case (mode_type'(req_if.mode))
            MODE_CHAR: begin
               if (sym.ok) begin
                  win_in    = win_shift;
                  run_in    = run_inc;
                  hit_count = (run_inc >= RUN_BITS'(k_eff));
               end else begin
                  // Any other character restarts the run.
                  win_in = '0;
                  run_in = '0;
               end
            end
            MODE_EOL: begin
               win_in = '0;
               run_in = '0;
            end
            MODE_READ: begin
               hit_read = 1'b1;
               rd_addr  = query_addr;
            end
            default: begin
               // No-op word: state untouched, zero response.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
         run_ff <= '0;
      end else begin
         win_ff <= win_in;
         run_ff <= run_in;
      end
   end

   // Stage B registers: control reset, address/payload not.
   logic          s1_count_ff;
   logic          s1_read_ff;
   logic [AW-1:0] s1_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_count_ff <= 1'b0;
         s1_read_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_count_ff <= hit_count;
         s1_read_ff  <= hit_read;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= rd_addr;
   end

   // ------------------------------------------------------------------
   // Counter RAM
   // ------------------------------------------------------------------
   logic                  ram_we;
   logic [AW-1:0]         ram_wa;
   logic [COUNT_BITS-1:0] ram_wd;
   logic [COUNT_BITS-1:0] ram_rd;

   kdc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   // ------------------------------------------------------------------
   // Stage B: forward the last write, saturate, write back
   // ------------------------------------------------------------------
   logic                  wb_valid_ff;
   logic [AW-1:0]         wb_addr_ff;
   logic [COUNT_BITS-1:0] wb_data_ff;
   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] new_count;
   logic                  do_write;

   // The RAM read issued at the edge of the previous write sees old data;
   // take the written value instead.
   assign cur_count = (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) ? wb_data_ff : ram_rd;
   assign new_count = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);
   assign do_write  = s1_valid_ff && s1_count_ff;

   assign ram_we = clr_busy_ff || do_write;
   assign ram_wa = clr_busy_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wd = clr_busy_ff ? '0 : new_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= do_write;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= s1_addr_ff;
      wb_data_ff <= new_count;
   end

   // ------------------------------------------------------------------
   // Output queue: three words, so stage B never stalls
   // ------------------------------------------------------------------
   logic                 out_counted;
   logic [WIDX_BITS-1:0] out_widx;
   logic [CVAL_BITS-1:0] out_cval;

   assign out_counted = s1_count_ff;
   assign out_widx    = s1_count_ff ? WIDX_BITS'(s1_addr_ff) : '0;
   assign out_cval    = s1_read_ff ? CVAL_BITS'(cur_count) : '0;

   logic                 q_counted_ff [FIFO_DEPTH];
   logic [WIDX_BITS-1:0] q_widx_ff    [FIFO_DEPTH];
   logic [CVAL_BITS-1:0] q_cval_ff    [FIFO_DEPTH];
   logic [1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           fifo_cnt_in;
   logic                 push, pop;

   assign push        = s1_valid_ff;
   assign pop         = rsp_if.valid && rsp_if.ready;
   assign fifo_cnt_in = fifo_cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == 2'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == 2'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_counted_ff[wr_ptr_ff] <= out_counted;
         q_widx_ff[wr_ptr_ff]    <= out_widx;
         q_cval_ff[wr_ptr_ff]    <= out_cval;
      end
   end

   assign rsp_if.valid        = (fifo_cnt_ff != 2'd0);
   assign rsp_if.counted      = q_counted_ff[rd_ptr_ff];
   assign rsp_if.window_index = q_widx_ff[rd_ptr_ff];
   assign rsp_if.count_value  = q_cval_ff[rd_ptr_ff];

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !accept)
      else $error("word accepted during clearing pass");

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      occupancy <= 3'(FIFO_DEPTH))
      else $error("output queue overflow");

   a_count_writes : assert property (@(posedge clock) disable iff (reset)
      (accept && hit_count) |=> (ram_we && (ram_wa == $past(rd_addr))))
      else $error("counted window not written back");

   a_sat_hold : assert property (@(posedge clock) disable iff (reset)
      (do_write && (&cur_count)) |-> (&ram_wd))
      else $error("saturated counter wrapped");

endmodule

### tb/kmer_count_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmer_count_checker
// Watches the request, response and register ports of the k-mer counter,
// keeps its own copy of the window, run and counter store, and compares each
// response word with the oldest predicted one.
// ----------------------------------------------------------------------------
module kmer_count_checker
   import kdc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [KLEN_BITS-1:0] csr_wr_data,
   kdc_req_if                   req_mon,
   kdc_rsp_if                   rsp_mon,
   output int                   fail_count,
   output int                   pending,
   output int                   windows_seen
);

   localparam int MAX_K      = 8;
   localparam int STORE_SIZE = 1 << (2 * MAX_K);

   typedef struct packed {
      logic                 counted;
      logic [WIDX_BITS-1:0] window_index;
      logic [CVAL_BITS-1:0] count_value;
   } result_type;

   result_type           expected_results [$];
   logic [KLEN_BITS-1:0] klen;
   logic [WIDX_BITS-1:0] window_bits;
   logic [RUN_BITS-1:0]  run_len;
   bit   [CVAL_BITS-1:0] kmer_counts [STORE_SIZE];

   // Advance the window and counters by one word; return the response it causes.
   function automatic result_type predict_word(input mode_type m,
                                               input logic [CHAR_BITS-1:0] ch,
                                               input logic [QUERY_BITS-1:0] q);
      result_type           res;
      logic [1:0]           base;
      bit                   is_base;
      int                   k;
      logic [WIDX_BITS-1:0] idx;
      res = '0;
      case (m)
         MODE_CHAR: begin
            is_base = 1'b1;
            base    = SYM_A;
            case (ch)
               CHAR_A:  base = SYM_A;
               CHAR_C:  base = SYM_C;
               CHAR_G:  base = SYM_G;
               CHAR_T:  base = SYM_T;
               default: is_base = 1'b0;
            endcase
            if (!is_base) begin
               window_bits = '0;
               run_len     = '0;
            end else begin
               k = (klen < K_MIN) ? int'(K_MIN) : ((klen > MAX_K) ? MAX_K : int'(klen));
               window_bits = {window_bits[WIDX_BITS-3:0], base};
               if (run_len < MAX_K) run_len = run_len + 1'b1;
               if (run_len >= k) begin
                  idx = window_bits & WIDX_BITS'((32'd1 << (2 * k)) - 1);
                  if (kmer_counts[idx] != '1) kmer_counts[idx] = kmer_counts[idx] + 1'b1;
                  res.counted      = 1'b1;
                  res.window_index = idx;
               end
            end
         end
         MODE_EOL: begin
            window_bits = '0;
            run_len     = '0;
         end
         MODE_READ: res.count_value = kmer_counts[q];
         default: ;
      endcase
      return res;
   endfunction

   // Sample at the falling edge: inputs and outputs are settled by then and
   // hold until the next rising edge, where the handshake takes effect.
   always @(negedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         expected_results.delete();
         klen        = K_RESET;
         window_bits = '0;
         run_len     = '0;
         foreach (kmer_counts[i]) kmer_counts[i] = '0;
         fail_count   = 0;
         windows_seen = 0;
      end else begin
         if (csr_wr_en) klen = csr_wr_data;
         // A response can never belong to a word accepted at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.counted, rsp_mon.window_index, rsp_mon.count_value};
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] unexpected response: counted=%0b index=%h count=%0d",
                           $realtime, got.counted, got.window_index, got.count_value);
            end else begin
               want = expected_results.pop_front();
               if (got.counted) windows_seen++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display(
                        "[%0t] mismatch exp/got: counted %0b/%0b index %h/%h count %0d/%0d",
                        $realtime, want.counted, got.counted, want.window_index,
                        got.window_index, want.count_value, got.count_value);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(predict_word(mode_type'(req_mon.mode),
                                                    req_mon.char_code,
                                                    req_mon.query_index));
      end
      pending = expected_results.size();
   end

endmodule

### tb/dna_kmer_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dna_kmer_counter_tb
// Stimulus and verdict for the k-mer counter: a directed opening over the
// character, line-end, read and unused modes, then random DNA text under a
// series of window lengths and handshake pacing; the checker beside the
// block predicts every response word.
// ----------------------------------------------------------------------------
module dna_kmer_counter_tb;
   import kdc_pkg::*;

   localparam int MAX_K      = 8;
   // Room for the clearing pass plus ~1800 words at heavy pacing, many times over.
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CHAR_BITS-1:0] BASE_CHAR [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

   typedef struct {
      logic [KLEN_BITS-1:0] klen;
      int                   idle_pct;
      int                   stall_pct;
      bit                   narrow;    // draw bases from A and C only
      int                   words;
      bit                   hold;      // block the response side for a long stretch
   } phase_type;

   // Window length settings cover the clamps below K_MIN and above MAX_K.
   phase_type plan [7] = '{
      '{4'd5,   0,  0, 1'b0, 260, 1'b0},
      '{4'd0,  61,  0, 1'b0, 257, 1'b0},
      '{4'd15,  0, 61, 1'b1, 257, 1'b0},
      '{4'd8,   0,  0, 1'b1, 257, 1'b1},
      '{4'd2,  15, 15, 1'b0, 257, 1'b0},
      '{4'd7,  15, 15, 1'b1, 257, 1'b0},
      '{4'd3,   0,  0, 1'b0, 257, 1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [KLEN_BITS-1:0] csr_wr_data;

   kdc_req_if req_if ();
   kdc_rsp_if rsp_if ();

   int fail_count;
   int pending;
   int windows_seen;
   int cycle_count = 0;
   int words_sent  = 0;
   int reads_sent  = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   bit narrow      = 1'b0;
   bit rsp_hold    = 1'b0;
   int klen_eff    = 3;

   dna_kmer_counter dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   kmer_count_checker chk (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .fail_count   (fail_count),
      .pending      (pending),
      .windows_seen (windows_seen)
   );

   always #4 clock = ~clock;

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
         $display("dna_kmer_counter verification failed");
         $finish;
      end
   end

   // Drive response ready: stall at the phase rate, hold low while a hold-off runs.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one word and return at the edge that accepts it; valid stays high
   // so back-to-back words never drop it within one step.
   task automatic send_word(input mode_type m, input logic [CHAR_BITS-1:0] ch,
                            input logic [QUERY_BITS-1:0] q);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= m;
      req_if.char_code   <= ch;
      req_if.query_index <= q;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      words_sent++;
      if (m == MODE_READ) reads_sent++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_word(MODE_CHAR, s[i], 16'($urandom));
   endtask

   // Drop valid and wait until every response word is back, plus the pipeline depth.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_klen(input logic [KLEN_BITS-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      klen_eff = (v < K_MIN) ? int'(K_MIN) : ((v > MAX_K) ? MAX_K : int'(v));
   endtask

   function automatic logic [1:0] pick_base();
      return narrow ? 2'($urandom_range(1)) : 2'($urandom_range(3));
   endfunction

   // Mostly DNA text with rare junk bytes and line ends; reads aim at windows
   // of the current length half the time so that they hit live counters.
   task automatic send_random(input int n);
      int                    roll;
      logic [CHAR_BITS-1:0]  ch;
      logic [QUERY_BITS-1:0] q;
      repeat (n) begin
         roll = $urandom_range(99);
         ch   = 8'($urandom_range(255));
         q    = 16'($urandom);
         if (roll < 80) begin
            if ($urandom_range(24) != 0) ch = BASE_CHAR[pick_base()];
            send_word(MODE_CHAR, ch, q);
         end else if (roll < 83) begin
            send_word(MODE_EOL, ch, q);
         end else if (roll < 98) begin
            if ($urandom_range(1) == 0) begin
               q = '0;
               repeat (klen_eff) q = {q[QUERY_BITS-3:0], pick_base()};
            end
            send_word(MODE_READ, ch, q);
         end else begin
            send_word(MODE_NOP, ch, q);
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_if.valid       <= 1'b0;
      req_if.mode        <= MODE_NOP;
      req_if.char_code   <= '0;
      req_if.query_index <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset window length of three; the block holds
      // ready low during its clearing pass, so the first word simply waits.
      send_text("ACGT");                                 // ACG and CGT counted
      send_text("NAAA");                                 // junk restarts the run; AAA counts
      send_word(MODE_EOL, 8'h00, 16'h0000);
      send_text("TTT");                                  // line end cleared AA: only TTT counts
      send_word(MODE_CHAR, 8'h00, 16'hFFFF);             // lowest byte restarts the run
      send_word(MODE_NOP, 8'hFF, 16'hFFFF);              // unused mode touches nothing
      send_word(MODE_READ, 8'hFF, 16'h0006);             // ACG
      send_word(MODE_READ, 8'h00, 16'h003F);             // TTT
      send_word(MODE_READ, 8'hFF, 16'hFFFF);             // top of the store
      send_word(MODE_READ, 8'h00, 16'h0000);             // AAA
      send_text("GATTA");                                // leave a five-base run open
      drain_results();

      // Random phases; the first length change lands mid-line on the open run.
      foreach (plan[p]) begin
         write_klen(plan[p].klen);
         idle_pct  = plan[p].idle_pct;
         stall_pct = plan[p].stall_pct;
         narrow    = plan[p].narrow;
         if (plan[p].hold) begin
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         send_random(plan[p].words);
         drain_results();
      end

      $display("covered %0d words (%0d counter reads) over %0d window settings",
               words_sent, reads_sent, $size(plan) + 1);
      $display("%0d windows counted, %0d responses left unanswered", windows_seen, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("dna_kmer_counter verification clean");
      end else begin
         $display("dna_kmer_counter verification failed");
      end
      $finish;
   end

endmodule
